/* design/tqle_pkg.sv */
`default_nettype none

package tqle_pkg;

  localparam int NUM_STATES  = 1024;
  localparam int NUM_ACTIONS = 4;
  localparam int VALUE_WIDTH = 32;
  localparam int STATE_W     = 10;
  localparam int ACT_W       = 2;
  localparam int FRAC_W      = 16;
  localparam int EPS_W       = 17;
  localparam int ROW_W       = NUM_ACTIONS * VALUE_WIDTH;

  typedef enum logic {
    OP_CHOOSE = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic {
    CFG_LEARNING_RATE   = 1'b0,
    CFG_DISCOUNT_FACTOR = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MAX,
    ST_DONE,
    ST_SCALE,
    ST_DIFF,
    ST_STEP,
    ST_WRITE
  } back_state_e;

  typedef struct packed {
    op_e                       opcode;
    logic [STATE_W-1:0]        state_index;
    logic [ACT_W-1:0]          action_index;
    logic signed [VALUE_WIDTH-1:0] reward;
    logic [STATE_W-1:0]        next_state_index;
    logic [EPS_W-1:0]          explore_threshold;
    logic [FRAC_W-1:0]         random_fraction;
    logic [ACT_W-1:0]          random_action;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]          chosen_action;
    logic                      explored;
    logic signed [VALUE_WIDTH-1:0] updated_value;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    op_e                       op;
    logic [STATE_W-1:0]        state_index;
    logic [ACT_W-1:0]          action_index;
    logic [VALUE_WIDTH-1:0]    reward;
    logic [STATE_W-1:0]        next_state_index;
    logic                      explore;
    logic [ACT_W-1:0]          random_action;
  } cmd_t;

  typedef struct packed {
    logic [FRAC_W-1:0] learning_rate;
    logic [FRAC_W-1:0] discount_factor;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

/* design/tqle_ram.sv */
`default_nettype none

module tqle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

/* design/tqle_fifo.sv */
`default_nettype none

module tqle_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* design/tqle_front.sv */
`default_nettype none

module tqle_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  input  wire tqle_pkg::in_item_t           in_data_i,
  output logic                              full,
  input  wire tqle_pkg::back_status_t       status_i,
  output logic                              cmd_valid_o,
  output tqle_pkg::cmd_t                    cmd_o,
  input  wire logic                         cmd_pop_i
);

  import tqle_pkg::*;

  cmd_t cmd_in;
  logic q_full, q_empty;

  // epsilon test: explore iff fraction < threshold
  always_comb begin
    cmd_in.op               = in_data_i.opcode;
    cmd_in.state_index      = in_data_i.state_index;
    cmd_in.action_index     = in_data_i.action_index;
    cmd_in.reward           = in_data_i.reward;
    cmd_in.next_state_index = in_data_i.next_state_index;
    cmd_in.explore          = ({1'b0, in_data_i.random_fraction} < in_data_i.explore_threshold);
    cmd_in.random_action    = in_data_i.random_action;
  end

  assign full        = q_full | status_i.clearing;
  assign cmd_valid_o = ~q_empty;

  tqle_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push & ~status_i.clearing),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (q_empty)
  );

endmodule

`default_nettype wire

/* design/tqle_back.sv */
`default_nettype none

module tqle_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tqle_pkg::cfg_t         cfg_i,
  input  wire logic                   cmd_valid_i,
  input  wire tqle_pkg::cmd_t         cmd_i,
  output logic                        cmd_pop_o,
  output tqle_pkg::back_status_t      status_o,
  input  wire logic                   pop,
  output logic                        empty,
  output tqle_pkg::out_item_t         out_data_o
);

  import tqle_pkg::*;

  localparam int P1_W = FRAC_W + 1 + VALUE_WIDTH;
  localparam int G_W  = P1_W - FRAC_W;
  localparam int D_W  = G_W + 2;
  localparam int P2_W = FRAC_W + 1 + D_W;
  localparam int S_W  = P2_W - FRAC_W;
  localparam int NV_W = S_W + 1;

  back_state_e state_q, state_d;
  logic [STATE_W-1:0] clr_cnt_q, clr_cnt_d;

  cmd_t                      cmd_q;
  logic [ROW_W-1:0]          row_cur, row_nxt, row_cur_q;
  logic [VALUE_WIDTH-1:0]    old_q, mx_q;
  logic [ACT_W-1:0]          best_q;
  logic signed [G_W-1:0]     g_q;
  logic signed [D_W-1:0]     d_q;
  logic signed [S_W-1:0]     step_q;

  logic [VALUE_WIDTH-1:0]    best_val, mx_val;
  logic [ACT_W-1:0]          best_idx;
  logic signed [P1_W-1:0]    prod1;
  logic signed [D_W-1:0]     d_val;
  logic signed [P2_W-1:0]    prod2;
  logic signed [NV_W-1:0]    nv_full;
  logic [VALUE_WIDTH-1:0]    nv;
  logic                      sat;
  logic [ROW_W-1:0]          row_wr;

  logic                      ram_we;
  logic [STATE_W-1:0]        ram_waddr;
  logic [ROW_W-1:0]          ram_wdata;
  logic                      res_push, res_full;
  out_item_t                 res_data;

  tqle_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_STATES)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (cmd_q.state_index),
    .raddr_b_i (cmd_q.next_state_index),
    .rdata_a_o (row_cur),
    .rdata_b_o (row_nxt)
  );

  // argmax of current row (ties to lowest) and max of next row
  always_comb begin
    best_val = row_cur[0 +: VALUE_WIDTH];
    best_idx = '0;
    mx_val   = row_nxt[0 +: VALUE_WIDTH];
    for (int k = 1; k < NUM_ACTIONS; k++) begin
      if ($signed(row_cur[k*VALUE_WIDTH +: VALUE_WIDTH]) > $signed(best_val)) begin
        best_val = row_cur[k*VALUE_WIDTH +: VALUE_WIDTH];
        best_idx = ACT_W'(k);
      end
      if ($signed(row_nxt[k*VALUE_WIDTH +: VALUE_WIDTH]) > $signed(mx_val)) begin
        mx_val = row_nxt[k*VALUE_WIDTH +: VALUE_WIDTH];
      end
    end
  end

  assign prod1 = $signed({1'b0, cfg_i.discount_factor}) * $signed(mx_q);
  assign d_val = $signed({{(D_W-VALUE_WIDTH){cmd_q.reward[VALUE_WIDTH-1]}}, cmd_q.reward})
               + $signed({{(D_W-G_W){g_q[G_W-1]}}, g_q})
               - $signed({{(D_W-VALUE_WIDTH){old_q[VALUE_WIDTH-1]}}, old_q});
  assign prod2 = $signed({1'b0, cfg_i.learning_rate}) * d_q;
  assign nv_full = $signed({{(NV_W-VALUE_WIDTH){old_q[VALUE_WIDTH-1]}}, old_q})
                 + $signed({step_q[S_W-1], step_q});

  always_comb begin
    sat = ~((&nv_full[NV_W-1:VALUE_WIDTH-1]) | ~(|nv_full[NV_W-1:VALUE_WIDTH-1]));
    if (!sat) begin
      nv = nv_full[VALUE_WIDTH-1:0];
    end else if (nv_full[NV_W-1]) begin
      nv = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      nv = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  end

  always_comb begin
    row_wr = row_cur_q;
    for (int k = 0; k < NUM_ACTIONS; k++) begin
      if (cmd_q.action_index == ACT_W'(k)) begin
        row_wr[k*VALUE_WIDTH +: VALUE_WIDTH] = nv;
      end
    end
  end

  // next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == STATE_W'(NUM_STATES-1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_MAX;
      ST_MAX:   state_d = (cmd_q.op == OP_UPDATE) ? ST_SCALE : ST_DONE;
      ST_DONE: begin
        if (!res_full) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCALE: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_STEP;
      ST_STEP:  state_d = ST_WRITE;
      ST_WRITE: begin
        if (!res_full) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o         = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = cmd_q.state_index;
    ram_wdata         = row_wr;
    res_push          = 1'b0;
    status_o.clearing = 1'b0;
    res_data          = '0;
    case (state_q)
      ST_CLEAR: begin
        status_o.clearing = 1'b1;
        ram_we            = 1'b1;
        ram_waddr         = clr_cnt_q;
        ram_wdata         = '0;
      end
      ST_IDLE: cmd_pop_o = cmd_valid_i;
      ST_DONE: begin
        res_push               = 1'b1;
        res_data.chosen_action = cmd_q.explore ? cmd_q.random_action : best_q;
        res_data.explored      = cmd_q.explore;
      end
      ST_WRITE: begin
        res_push               = 1'b1;
        ram_we                 = ~res_full;
        res_data.updated_value = nv;
        res_data.saturated     = sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_MAX) begin
      row_cur_q <= row_cur;
      old_q     <= row_cur[cmd_q.action_index*VALUE_WIDTH +: VALUE_WIDTH];
      mx_q      <= mx_val;
      best_q    <= best_idx;
    end
    if (state_q == ST_SCALE) begin
      g_q <= prod1[P1_W-1:FRAC_W];
    end
    if (state_q == ST_DIFF) begin
      d_q <= d_val;
    end
    if (state_q == ST_STEP) begin
      step_q <= prod2[P2_W-1:FRAC_W];
    end
  end

  tqle_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_data_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

/* design/tabular_q_learning_engine.sv */
// Tabular Q-learning engine: 1024 states x 4 actions of signed Q16.16 values.
// After reset the table is zeroed by a clearing pass over all 1024 rows, during
// which full stays high; configuration writes are taken at any time. The
// back-end sequencer handles one item at a time: a choose item passes row
// read and max/argmax, an update item row read, max/argmax, gamma multiply,
// difference, alpha multiply, saturate and write-back through the single
// table write port. Items are buffered two deep on entry and results two
// deep on exit, so push and pop may stall independently.
`default_nettype none

module tabular_q_learning_engine (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  input  wire tqle_pkg::in_item_t      in_data_i,
  output logic                         full,
  input  wire logic                    pop,
  output logic                         empty,
  output tqle_pkg::out_item_t          out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire tqle_pkg::cfg_idx_e      cfg_index_i,
  input  wire logic [15:0]             cfg_data_i
);

  import tqle_pkg::*;

  cfg_t         cfg_q;
  back_status_t status;
  logic         cmd_valid, cmd_pop;
  cmd_t         cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate   <= FRAC_W'(6554);
      cfg_q.discount_factor <= FRAC_W'(58982);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEARNING_RATE:   cfg_q.learning_rate   <= cfg_data_i;
        CFG_DISCOUNT_FACTOR: cfg_q.discount_factor <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tqle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_data_i   (in_data_i),
    .full        (full),
    .status_i    (status),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tqle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .status_o    (status),
    .pop         (pop),
    .empty       (empty),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/tqle_checker.sv */
`timescale 1ns / 100ps

module tqle_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  tqle_pkg::in_item_t   in_data_i,
  input  logic                 pop_i,
  input  logic                 empty_i,
  input  tqle_pkg::out_item_t  out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  tqle_pkg::cfg_idx_e   cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import tqle_pkg::*;

  localparam logic [FRAC_W-1:0] ALPHA_RESET = 16'd6554;
  localparam logic [FRAC_W-1:0] GAMMA_RESET = 16'd58982;
  localparam longint VALUE_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint VALUE_MIN = -VALUE_MAX - 1;
  localparam int REPORT_LIMIT = 10;

  logic signed [VALUE_WIDTH-1:0] q_table [NUM_STATES][NUM_ACTIONS];
  logic [FRAC_W-1:0] alpha_q;
  logic [FRAC_W-1:0] gamma_q;
  // newest at the front, oldest at the back
  out_item_t result_q[$];
  int failures;

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic [STATE_W-1:0] s;
    logic [STATE_W-1:0] ns;
    logic [ACT_W-1:0] a;
    logic [ACT_W-1:0] best;
    longint old_v, max_next, disc, diff, lo, step, nv, alpha_l, gamma_l;
    r = '0;
    s = it.state_index;
    ns = it.next_state_index;
    a = it.action_index;
    if (it.opcode == OP_CHOOSE) begin
      if ({1'b0, it.random_fraction} < it.explore_threshold) begin
        r.explored = 1'b1;
        r.chosen_action = it.random_action;
      end else begin
        best = '0;
        for (int k = 1; k < NUM_ACTIONS; k++)
          if (q_table[s][k] > q_table[s][best]) best = ACT_W'(k);
        r.chosen_action = best;
      end
    end else begin
      alpha_l = longint'(alpha_q);
      gamma_l = longint'(gamma_q);
      old_v = q_table[s][a];
      max_next = q_table[ns][0];
      for (int k = 1; k < NUM_ACTIONS; k++)
        if (q_table[ns][k] > max_next) max_next = q_table[ns][k];
      disc = (gamma_l * max_next) >>> 16;
      diff = longint'($signed(it.reward)) + disc - old_v;
      lo = diff & 64'sh0000_0000_0000_FFFF;
      step = alpha_l * (diff >>> 16) + ((alpha_l * lo) >>> 16);
      nv = old_v + step;
      if (nv > VALUE_MAX) begin
        nv = VALUE_MAX;
        r.saturated = 1'b1;
      end else if (nv < VALUE_MIN) begin
        nv = VALUE_MIN;
        r.saturated = 1'b1;
      end
      q_table[s][a] = nv[VALUE_WIDTH-1:0];
      r.updated_value = nv[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STATES; i++)
        for (int k = 0; k < NUM_ACTIONS; k++) q_table[i][k] = '0;
      alpha_q = ALPHA_RESET;
      gamma_q = GAMMA_RESET;
      result_q.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (result_q.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("tqle_checker: unexpected result transfer at %0t", $realtime);
        end else begin
          want = result_q.pop_back();
          if (out_data_i.chosen_action !== want.chosen_action ||
              out_data_i.explored !== want.explored ||
              out_data_i.updated_value !== want.updated_value ||
              out_data_i.saturated !== want.saturated) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $write("tqle_checker: mismatch at %0t: expected action %0d explored %0b",
                     $realtime, want.chosen_action, want.explored);
              $display(" value %0d sat %0b; got action %0d explored %0b value %0d sat %0b",
                       $signed(want.updated_value), want.saturated,
                       out_data_i.chosen_action, out_data_i.explored,
                       $signed(out_data_i.updated_value), out_data_i.saturated);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LEARNING_RATE:   alpha_q = cfg_data_i;
          CFG_DISCOUNT_FACTOR: gamma_q = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) result_q.push_front(predict_result(in_data_i));
      fail_count_o <= failures;
      pending_o <= result_q.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import tqle_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 32;
  localparam int RESET_CYCLES = 12;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 64;
  localparam logic [31:0] REWARD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] REWARD_MIN = 32'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  in_item_t in_data = '0;
  cfg_idx_e cfg_index = CFG_LEARNING_RATE;
  logic [15:0] cfg_data = '0;
  logic full;
  logic empty;
  logic cfg_ready;
  out_item_t out_data;
  int fail_count;
  int pending;
  int cycles = 0;
  int idle_mode = 0;

  tabular_q_learning_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_data_i   (in_data),
    .full        (full),
    .pop         (pop),
    .empty       (empty),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tqle_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_data_i    (in_data),
    .pop_i        (pop),
    .empty_i      (empty),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // idle_mode: 0 both sides idle, 1 neither, 2 sender only, 3 receiver only
  function automatic int draw_gap(bit enabled);
    return enabled ? int'($urandom_range(0, 7)) : 0;
  endfunction

  function automatic in_item_t mk_item(op_e op, int s, int a, logic [31:0] r, int ns,
                                       int thr, int frac, int ra);
    in_item_t it;
    it.opcode = op;
    it.state_index = STATE_W'(s);
    it.action_index = ACT_W'(a);
    it.reward = r;
    it.next_state_index = STATE_W'(ns);
    it.explore_threshold = EPS_W'(thr);
    it.random_fraction = FRAC_W'(frac);
    it.random_action = ACT_W'(ra);
    return it;
  endfunction

  function automatic int pick_state();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_STATES - 1)
                                       : $urandom_range(0, 15);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.opcode = $urandom_range(0, 1) ? OP_UPDATE : OP_CHOOSE;
    it.state_index = STATE_W'(pick_state());
    it.next_state_index = ($urandom_range(0, 4) == 0) ? it.state_index
                                                       : STATE_W'(pick_state());
    it.action_index = ACT_W'($urandom_range(0, NUM_ACTIONS - 1));
    it.random_action = ACT_W'($urandom_range(0, NUM_ACTIONS - 1));
    case ($urandom_range(0, 3))
      0: it.reward = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
      1: it.reward = $urandom;
      2: it.reward = $urandom_range(0, 1) ? REWARD_MAX : REWARD_MIN;
      default: it.reward = $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
    endcase
    it.random_fraction = FRAC_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0: it.explore_threshold = '0;
      1: it.explore_threshold = 17'd65536;
      2: it.explore_threshold = {1'b0, it.random_fraction};
      3: it.explore_threshold = {1'b0, it.random_fraction} + 17'd1;
      4: it.explore_threshold = EPS_W'($urandom_range(0, 65536));
      default: it.explore_threshold = EPS_W'($urandom_range(0, 131071));
    endcase
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = draw_gap(idle_mode == 0 || idle_mode == 2);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (full);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_rates(logic [15:0] lr, logic [15:0] df);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LEARNING_RATE;
    cfg_data <= lr;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_DISCOUNT_FACTOR;
    cfg_data <= df;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_side
    int gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(idle_mode == 0 || idle_mode == 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : stimulus
    logic [15:0] lr;
    logic [15:0] df;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // explore boundary, ties, extremes at reset rates
    send_item(mk_item(OP_CHOOSE, 0, 1, $urandom, 7, 0, 0, 2));
    send_item(mk_item(OP_CHOOSE, 1023, 0, $urandom, 1023, 65536, 65535, 3));
    send_item(mk_item(OP_CHOOSE, 0, 2, $urandom, 3, 1, 0, 1));
    send_item(mk_item(OP_CHOOSE, 0, 3, $urandom, 4, 1, 1, 1));
    send_item(mk_item(OP_CHOOSE, 512, 0, $urandom, 0, 131071, 65535, 2));
    send_item(mk_item(OP_UPDATE, 1023, 3, REWARD_MAX, 1023, 0, 0, 0));
    send_item(mk_item(OP_UPDATE, 1023, 2, REWARD_MIN, 0, 131071, 65535, 3));
    send_item(mk_item(OP_CHOOSE, 1023, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_UPDATE, 5, 1, 32'h0001_0000, 1023, 0, 0, 0));
    send_item(mk_item(OP_UPDATE, 5, 2, 32'h0001_0000, 1023, 0, 0, 0));
    send_item(mk_item(OP_CHOOSE, 5, 0, 0, 0, 0, 0, 3));
    send_item(mk_item(OP_UPDATE, 1023, 0, 32'hFFFF_FFFF, 5, 0, 0, 0));
    wait_idle();

    // saturation both ways at full rates
    set_rates(16'hFFFF, 16'hFFFF);
    repeat (3) send_item(mk_item(OP_UPDATE, 7, 0, REWARD_MAX, 7, 0, 0, 0));
    for (int k = 0; k < NUM_ACTIONS; k++)
      send_item(mk_item(OP_UPDATE, 8, k, REWARD_MIN, 9, 0, 0, 0));
    send_item(mk_item(OP_UPDATE, 8, 0, REWARD_MIN, 8, 0, 0, 0));
    send_item(mk_item(OP_CHOOSE, 8, 0, 0, 0, 0, 0, 0));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lr = 16'hFFFF; df = 16'hFFFF; end
        1: begin lr = 16'h0000; df = 16'h0000; end
        2: begin lr = 16'hFFFF; df = 16'h0000; end
        3: begin lr = 16'h0000; df = 16'hFFFF; end
        4: begin lr = 16'($urandom); df = 16'($urandom); end
        default: begin lr = 16'd6554; df = 16'd58982; end
      endcase
      set_rates(lr, df);
      idle_mode = p % 4;
      repeat (ITEMS_PER_PHASE) send_item(rand_item());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

/* tabular_q_learning_engine.f */
design/tqle_pkg.sv
design/tqle_ram.sv
design/tqle_fifo.sv
design/tqle_front.sv
design/tqle_back.sv
design/tabular_q_learning_engine.sv
tb/tqle_checker.sv
tb/tb.sv
